// File: hw/rtl/acs_pkg.sv
// access chunk splitter package: field widths, chunk sizes and the
// command/status structs shared by the controller, datapath and top level
// no dependencies
package acs_pkg;

  // field widths
  localparam int ADDR_W = 48;
  localparam int LEN_W  = 9;
  localparam int TID_W  = 3;
  localparam int REC_W  = ADDR_W + TID_W + 1;
  localparam int CNT_W  = 32;
  localparam int SIZE_W = 4;

  // line size default and clamp on the access length
  localparam int DEF_LOG_LINE_BYTES = 6;
  localparam logic [LEN_W-1:0] MAX_BYTES = LEN_W'(256);

  // chunk sizes
  localparam logic [SIZE_W-1:0] CHUNK_8 = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] CHUNK_4 = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] CHUNK_2 = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] CHUNK_1 = SIZE_W'(1);

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new access into the working registers
    logic emit;   // issue one chunk into the output register
  } acs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a chunk this cycle
    logic last;       // the chunk at hand ends the access
    logic len_nz;     // the offered access has a nonzero length
  } acs_status_t;

endpackage

// File: hw/rtl/access_chunk_splitter_unit.sv
// access chunk splitter top level: splits one memory access into chunk records
// instantiates acs_ctrl and acs_dp; uses acs_pkg
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | address, access_bytes, thread_id, is_write
//   out     | out_valid/out_stall| packed_record, last_chunk, records_so_far
//
// one record leaves per cycle while out_stall is low, and the next access is
// taken in the cycle its last chunk issues
// the loop of one chunk per cycle through the address adder sets this figure
// a zero-length access is accepted and yields nothing
// rst_n clears the state machine, the output valid and the record count
// out_stall holds the output register; the splitter waits with it
module access_chunk_splitter_unit #(
  parameter int LOG_LINE_BYTES = acs_pkg::DEF_LOG_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [acs_pkg::ADDR_W-1:0]  in_address,
  input  logic [acs_pkg::LEN_W-1:0]   in_access_bytes,
  input  logic [acs_pkg::TID_W-1:0]   in_thread_id,
  input  logic                        in_is_write,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [acs_pkg::REC_W-1:0]   out_packed_record,
  output logic                        out_last_chunk,
  output logic [acs_pkg::CNT_W-1:0]   out_records_so_far
);
  import acs_pkg::*;

  acs_cmd_t    cmd;
  acs_status_t status;

  // sequencing
  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // address, length and record path
  acs_dp #(
    .LOG_LINE_BYTES (LOG_LINE_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_address         (in_address),
    .in_access_bytes    (in_access_bytes),
    .in_thread_id       (in_thread_id),
    .in_is_write        (in_is_write),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packed_record  (out_packed_record),
    .out_last_chunk     (out_last_chunk),
    .out_records_so_far (out_records_so_far),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

// File: hw/rtl/acs_ctrl.sv
// access chunk splitter controller: idle/run state machine
// drives load and emit commands from datapath status; uses acs_pkg
module acs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acs_pkg::acs_status_t status,
  output acs_pkg::acs_cmd_t    cmd
);
  import acs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic free_in;
  logic accept;

  // a new access may enter while idle or while the final chunk is issued
  always_comb begin
    cmd.emit = (state_r == ST_RUN) && status.slot_free;
    free_in  = (state_r == ST_IDLE) || (cmd.emit && status.last);
    accept   = in_valid && free_in;
    cmd.load = accept;
    in_stall = !free_in;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = status.len_nz ? ST_RUN : ST_IDLE;
    end else if (cmd.emit && status.last) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/acs_dp.sv
// access chunk splitter datapath: working address and length, chunk sizing,
// output register and record counter; uses acs_pkg
module acs_dp #(
  parameter int LOG_LINE_BYTES = acs_pkg::DEF_LOG_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [acs_pkg::ADDR_W-1:0]  in_address,
  input  logic [acs_pkg::LEN_W-1:0]   in_access_bytes,
  input  logic [acs_pkg::TID_W-1:0]   in_thread_id,
  input  logic                        in_is_write,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [acs_pkg::REC_W-1:0]   out_packed_record,
  output logic                        out_last_chunk,
  output logic [acs_pkg::CNT_W-1:0]   out_records_so_far,
  input  acs_pkg::acs_cmd_t           cmd,
  output acs_pkg::acs_status_t        status
);
  import acs_pkg::*;

  localparam int LineBytes = 1 << LOG_LINE_BYTES;

  // working registers of the access in flight
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [TID_W-1:0]  tid_r, tid_nxt;
  logic              wr_r, wr_nxt;

  // output register and record count
  logic              ovalid_r, ovalid_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  logic              olast_r, olast_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [LEN_W-1:0]  room;
  logic [LEN_W-1:0]  seg;
  logic [SIZE_W-1:0] size;
  logic [LEN_W-1:0]  len_clamped;

  // bytes left in the current line segment
  always_comb begin
    room = LEN_W'(LineBytes) - LEN_W'(cur_r[LOG_LINE_BYTES-1:0]);
    seg  = (rem_r < room) ? rem_r : room;
  end

  // largest chunk that still fits the segment
  always_comb begin
    priority if (seg >= LEN_W'(CHUNK_8)) begin
      size = CHUNK_8;
    end else if (seg[2]) begin
      size = CHUNK_4;
    end else if (seg[1]) begin
      size = CHUNK_2;
    end else begin
      size = CHUNK_1;
    end
  end

  // status back to the controller
  always_comb begin
    len_clamped      = in_access_bytes[LEN_W-1] ? MAX_BYTES : in_access_bytes;
    status.len_nz    = (len_clamped != '0);
    status.last      = (rem_r == LEN_W'(size));
    status.slot_free = !ovalid_r || !out_stall;
  end

  // working register update
  always_comb begin
    cur_nxt = cur_r;
    rem_nxt = rem_r;
    tid_nxt = tid_r;
    wr_nxt  = wr_r;
    if (cmd.load) begin
      cur_nxt = in_address;
      rem_nxt = len_clamped;
      tid_nxt = in_thread_id;
      wr_nxt  = in_is_write;
    end else if (cmd.emit) begin
      cur_nxt = cur_r + ADDR_W'(size);
      rem_nxt = rem_r - LEN_W'(size);
    end
  end

  // output register and running count
  always_comb begin
    ovalid_nxt = ovalid_r && out_stall;
    rec_nxt    = rec_r;
    olast_nxt  = olast_r;
    cnt_nxt    = cnt_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      rec_nxt    = {cur_r, tid_r, wr_r};
      olast_nxt  = status.last;
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    rem_r   <= rem_nxt;
    tid_r   <= tid_nxt;
    wr_r    <= wr_nxt;
    rec_r   <= rec_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_packed_record  = rec_r;
  assign out_last_chunk     = olast_r;
  assign out_records_so_far = cnt_r;

endmodule

// File: tb/acs_chunk_checker.sv
`timescale 1ns / 100ps
// chunk record checker for the access chunk splitter: watches both channels,
// predicts the chunk records of each accepted item and compares them in order
// depends on acs_pkg
module acs_chunk_checker #(
  parameter int LOG_LINE = acs_pkg::DEF_LOG_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [acs_pkg::ADDR_W-1:0]  in_address,
  input  logic [acs_pkg::LEN_W-1:0]   in_access_bytes,
  input  logic [acs_pkg::TID_W-1:0]   in_thread_id,
  input  logic                        in_is_write,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [acs_pkg::REC_W-1:0]   out_packed_record,
  input  logic                        out_last_chunk,
  input  logic [acs_pkg::CNT_W-1:0]   out_records_so_far,
  output int                          mismatches,
  output int                          pending
);
  import acs_pkg::*;

  localparam int LINE_BYTES = 1 << LOG_LINE;

  typedef struct packed {
    logic [REC_W-1:0] rec;
    logic             last;
    logic [CNT_W-1:0] count;
  } chunk_rec_t;

  chunk_rec_t       chunk_q[$];
  chunk_rec_t       want;
  logic [CNT_W-1:0] record_tally;
  int               mismatch_count = 0;
  int               pending_count = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, exp_val);
    mismatch_count++;
  endtask

  // count one chunk and queue its record
  task automatic add_chunk(input logic [ADDR_W-1:0] at, input logic [TID_W-1:0] tid,
                           input logic wr);
    chunk_rec_t r;
    record_tally = record_tally + 1'b1;
    r.rec   = {at, tid, wr};
    r.last  = 1'b0;
    r.count = record_tally;
    chunk_q.push_back(r);
  endtask

  // cut an access at line boundaries, then each segment into 8/4/2/1 chunks
  task automatic split_access(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                              input logic [TID_W-1:0] tid, input logic wr);
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] pos;
    int unsigned       left;
    int unsigned       room;
    int unsigned       seg;
    int                queued_before;
    chunk_rec_t        r;
    queued_before = chunk_q.size();
    left = (len > MAX_BYTES) ? int'(MAX_BYTES) : int'(len);
    cur  = addr;
    while (left > 0) begin
      room = LINE_BYTES - int'(cur[LOG_LINE-1:0]);
      seg  = (left < room) ? left : room;
      pos  = cur;
      for (int i = 0; i < int'(seg / 8); i++) begin
        add_chunk(pos, tid, wr);
        pos = pos + ADDR_W'(8);
      end
      for (int sz = 4; sz >= 1; sz = sz / 2) begin
        if ((seg & sz) != 0) begin
          add_chunk(pos, tid, wr);
          pos = pos + ADDR_W'(sz);
        end
      end
      left = left - seg;
      cur  = cur + ADDR_W'(seg);
    end
    // mark the final chunk of this access
    if (chunk_q.size() > queued_before) begin
      r = chunk_q.pop_back();
      r.last = 1'b1;
      chunk_q.push_back(r);
    end
  endtask

  // predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin
    if (!rst_n) begin
      chunk_q.delete();
      record_tally = '0;
    end else begin
      if (in_valid && !in_stall) begin
        split_access(in_address, in_access_bytes, in_thread_id, in_is_write);
      end
      if (out_valid && !out_stall) begin
        if (chunk_q.size() == 0) begin
          report_mismatch("unexpected record", 64'(out_packed_record), 64'd0);
        end else begin
          want = chunk_q.pop_front();
          if (out_packed_record !== want.rec) begin
            report_mismatch("packed_record", 64'(out_packed_record), 64'(want.rec));
          end
          if (out_last_chunk !== want.last) begin
            report_mismatch("last_chunk", 64'(out_last_chunk), 64'(want.last));
          end
          if (out_records_so_far !== want.count) begin
            report_mismatch("records_so_far", 64'(out_records_so_far), 64'(want.count));
          end
        end
      end
    end
    pending_count = chunk_q.size();
  end

endmodule

// File: tb/tb_access_chunk_splitter_unit.sv
`timescale 1ns / 100ps
// testbench top for access_chunk_splitter_unit: clock, reset, access stimulus
// and the verdict; depends on acs_pkg, the block and acs_chunk_checker
module tb_access_chunk_splitter_unit;
  import acs_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int TAIL_CYCLES     = 40;
  localparam int ITEMS_PER_PHASE = 38;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ADDR_W-1:0] in_address;
  logic [LEN_W-1:0]  in_access_bytes;
  logic [TID_W-1:0]  in_thread_id;
  logic              in_is_write;
  logic              out_valid;
  logic              out_stall;
  logic [REC_W-1:0]  out_packed_record;
  logic              out_last_chunk;
  logic [CNT_W-1:0]  out_records_so_far;
  int                mismatches;
  int                pending;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                cycle_count = 0;

  always #5 clk = ~clk;

  access_chunk_splitter_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .in_access_bytes    (in_access_bytes),
    .in_thread_id       (in_thread_id),
    .in_is_write        (in_is_write),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packed_record  (out_packed_record),
    .out_last_chunk     (out_last_chunk),
    .out_records_so_far (out_records_so_far)
  );

  acs_chunk_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .in_access_bytes    (in_access_bytes),
    .in_thread_id       (in_thread_id),
    .in_is_write        (in_is_write),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packed_record  (out_packed_record),
    .out_last_chunk     (out_last_chunk),
    .out_records_so_far (out_records_so_far),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // random receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one access, with random idle cycles ahead of it, until it is taken
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                             input logic [TID_W-1:0] tid, input logic wr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_address      <= addr;
    in_access_bytes <= len;
    in_thread_id    <= tid;
    in_is_write     <= wr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender off until every predicted record has come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    int                pick;
    int                sent;
    int                phase;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_address      = '0;
    in_access_bytes = '0;
    in_thread_id    = '0;
    in_is_write     = 1'b0;
    out_stall       = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed accesses
    send_idle_pct = 33;
    recv_idle_pct = 59;
    send_access(48'h0, 9'd1, 3'd0, 1'b0);
    send_access(48'h0, 9'd8, 3'd7, 1'b1);
    send_access(48'h3, 9'd7, 3'd1, 1'b0);                 // 4, 2 and 1 byte tail
    send_access(48'h3f, 9'd2, 3'd2, 1'b1);                // straddles a line
    send_access(48'h40, 9'd64, 3'd3, 1'b0);               // exactly one line
    send_access(48'h1, 9'd256, 3'd4, 1'b1);               // most records per access
    send_access(48'h0, 9'd256, 3'd5, 1'b0);
    send_access(48'h100, 9'd0, 3'd6, 1'b1);               // zero length
    send_access(48'h0, 9'd0, 3'd0, 1'b0);
    send_access(48'h7, 9'd257, 3'd0, 1'b1);               // oversize, clamped
    send_access(48'h20, 9'h1ff, 3'd7, 1'b0);
    send_access(48'hFFFF_FFFF_FFFC, 9'd16, 3'd5, 1'b1);   // wraps past the top
    send_access(48'hFFFF_FFFF_FFFF, 9'd3, 3'd2, 1'b0);
    send_access(48'hFFFF_FFFF_FFC1, 9'd256, 3'd6, 1'b1);
    send_access(48'hAAAA_AAAA_AAAA, 9'd15, 3'd5, 1'b0);
    send_access(48'h5555_5555_5555, 9'd63, 3'd2, 1'b1);
    send_access(48'h7FFF_FFFF_FFF9, 9'd128, 3'd1, 1'b0);

    // random accesses: three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 33 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          addr = ADDR_W'({$urandom, $urandom});
        end else if (pick < 80) begin
          addr = {40'hFF_FFFF_FFFF, 8'($urandom)};
        end else begin
          addr = ADDR_W'($urandom_range(255));
        end
        // mostly short accesses, some long, a few oversize or empty
        pick = $urandom_range(99);
        if (pick < 70) begin
          len = LEN_W'($urandom_range(16, 1));
        end else if (pick < 85) begin
          len = LEN_W'($urandom_range(64, 17));
        end else if (pick < 93) begin
          len = LEN_W'($urandom_range(256, 65));
        end else if (pick < 97) begin
          len = LEN_W'($urandom_range(511, 257));
        end else begin
          len = '0;
        end
        send_access(addr, len, TID_W'($urandom), 1'($urandom));
        if (len != 0) begin
          sent++;
          if (phase == 0 && sent == ITEMS_PER_PHASE / 2) begin
            wait_for_drain();
          end
        end
      end
    end

    // let everything drain, then watch for stray records
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/acs_pkg.sv
hw/rtl/acs_ctrl.sv
hw/rtl/acs_dp.sv
hw/rtl/access_chunk_splitter_unit.sv
tb/acs_chunk_checker.sv
tb/tb_access_chunk_splitter_unit.sv
